// File: design/tma_pkg.sv
// shared constants, types and tables for the triangle minimum angle block
package tma_pkg;

    // input coordinate and result formats
    localparam int COORD_WIDTH     = 24;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int OUT_W           = 8 + ANGLE_FRAC_BITS;

    // edge vector and normalized vector widths
    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int POS_W    = $clog2(DIFF_W);
    localparam int NORM_MSB = 23;
    localparam int NORM_W   = NORM_MSB + 2;
    localparam int SHIFT_W  = 5;

    // dot product and magnitude datapath widths
    localparam int PROD_W = 2 * NORM_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = SUM_W - 1;
    localparam int WIDE_W = 64;
    localparam int ROOT_W = 31;
    localparam int SQ_PRE = 12;
    localparam int CQ     = 30;

    // iteration counts
    localparam int SQRT_STEPS   = WIDE_W / 2;
    localparam int DIV_STEPS    = CQ;
    localparam int CORDIC_STEPS = 20;

    // cordic and angle widths (degrees, 16 fraction bits)
    localparam int XY_W  = 34;
    localparam int Z_W   = 25;
    localparam int ANG_W = 24;

    localparam logic [ANG_W-1:0]        DEG180_Q16 = ANG_W'(180 << 16);
    localparam logic signed [Z_W-1:0]   DEG90_Q16  = Z_W'(90 << 16);
    localparam logic [OUT_W-1:0]        MAX_ANGLE  = OUT_W'(180 << ANGLE_FRAC_BITS);

    // rounding of the q16 minimum down to the output fraction bits
    localparam int             RND_SH    = 16 - ANGLE_FRAC_BITS;
    localparam logic [ANG_W:0] ROUND_INC = (ANG_W + 1)'((1 << RND_SH) >> 1);

    // arctangent of 2^-i in degrees, q16
    localparam logic [Z_W-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
        Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945), Z_W'(234379),
        Z_W'(117304),  Z_W'(58666),   Z_W'(29335),  Z_W'(14668),  Z_W'(7334),
        Z_W'(3667),    Z_W'(1833),    Z_W'(917),    Z_W'(458),    Z_W'(229),
        Z_W'(115),     Z_W'(57),      Z_W'(29),     Z_W'(14),     Z_W'(7)
    };

    // control that travels with each item
    typedef struct packed {
        logic valid;
        logic degen;
    } ctl_t;

    // square root iteration state
    typedef struct packed {
        logic [WIDE_W-1:0] n;
        logic [WIDE_W-1:0] r;
    } sq_t;

    // restoring divider iteration state
    typedef struct packed {
        logic [WIDE_W-1:0] rem;
        logic [ROOT_W-1:0] q;
    } dv_t;

endpackage

// File: design/tma_vec_angle.sv
// pipelined angle between two normalized vectors, degrees q16
module tma_vec_angle (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tma_pkg::ctl_t                      ctl_in,
    input  logic signed [tma_pkg::NORM_W-1:0]  ux,
    input  logic signed [tma_pkg::NORM_W-1:0]  uy,
    input  logic signed [tma_pkg::NORM_W-1:0]  uz,
    input  logic signed [tma_pkg::NORM_W-1:0]  vx,
    input  logic signed [tma_pkg::NORM_W-1:0]  vy,
    input  logic signed [tma_pkg::NORM_W-1:0]  vz,
    output tma_pkg::ctl_t                      ctl_out,
    output logic [tma_pkg::ANG_W-1:0]          angle
);
    import tma_pkg::*;

    // one square root digit step
    function automatic sq_t sqrt_step(input sq_t s, input logic [WIDE_W-1:0] b);
        sq_t               o;
        logic [WIDE_W-1:0] t;
        t = s.r + b;
        if (s.n >= t)
        begin
            o.n = s.n - t;
            o.r = (s.r >> 1) + b;
        end
        else
        begin
            o.n = s.n;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // one quotient bit step
    function automatic dv_t div_step(input dv_t s, input logic [WIDE_W-1:0] den);
        dv_t               o;
        logic [WIDE_W-1:0] r2;
        r2 = s.rem << 1;
        if (r2 >= den)
        begin
            o.rem = r2 - den;
            o.q   = {s.q[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2;
            o.q   = {s.q[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // control per stage
    ctl_t p1_ctl_reg, p2_ctl_reg, dn_ctl_reg, cc_ctl_reg, cs_ctl_reg, out_ctl_reg;
    ctl_t sq_ctl_reg [SQRT_STEPS+1];
    ctl_t dv_ctl_reg [DIV_STEPS+1];
    ctl_t ps_ctl_reg [SQRT_STEPS+1];
    ctl_t co_ctl_reg [CORDIC_STEPS+1];

    // products and sums
    logic signed [PROD_W-1:0] prod_uv_reg [3];
    logic signed [PROD_W-1:0] prod_uu_reg [3];
    logic signed [PROD_W-1:0] prod_vv_reg [3];
    logic signed [SUM_W-1:0]  dot_reg;
    logic [SUM_W-1:0]         su_reg;
    logic [SUM_W-1:0]         sv_reg;

    // magnitude square roots
    sq_t              sqa_reg [SQRT_STEPS+1];
    sq_t              sqb_reg [SQRT_STEPS+1];
    logic             sq_neg_reg [SQRT_STEPS+1];
    logic [MAG_W-1:0] sq_mag_reg [SQRT_STEPS+1];

    // cosine division
    logic [WIDE_W-1:0] den_reg;
    logic [WIDE_W-1:0] num_reg;
    logic              dn_neg_reg;
    dv_t               dv_reg [DIV_STEPS+1];
    logic [WIDE_W-1:0] dv_den_reg [DIV_STEPS+1];
    logic              dv_sat_reg [DIV_STEPS+1];
    logic              dv_neg_reg [DIV_STEPS+1];

    // sine from cosine
    logic [ROOT_W-1:0] cc_c_reg;
    logic              cc_neg_reg;
    logic [WIDE_W-1:0] csq_reg;
    logic [ROOT_W-1:0] cs_c_reg;
    logic              cs_neg_reg;
    sq_t               ps_reg [SQRT_STEPS+1];
    logic [ROOT_W-1:0] ps_c_reg [SQRT_STEPS+1];
    logic              ps_neg_reg [SQRT_STEPS+1];

    // cordic vectoring
    logic signed [XY_W-1:0] co_x_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] co_y_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  co_z_reg [CORDIC_STEPS+1];
    logic                   co_neg_reg [CORDIC_STEPS+1];
    logic [ANG_W-1:0]       angle_reg;

    logic [WIDE_W-1:0]      mu_w, mv_w, c_w;
    logic [ANG_W-1:0]       angle_next;
    logic signed [Z_W-1:0]  zc;

    assign mu_w = WIDE_W'(sqa_reg[SQRT_STEPS].r[ROOT_W-1:0]);
    assign mv_w = WIDE_W'(sqb_reg[SQRT_STEPS].r[ROOT_W-1:0]);
    assign c_w  = WIDE_W'(cc_c_reg);

    // clamp cordic angle and fold by the dot product sign
    always_comb
    begin
        zc = co_z_reg[CORDIC_STEPS];
        if (zc < 0)
            zc = '0;
        else if (zc > DEG90_Q16)
            zc = DEG90_Q16;
        if (co_neg_reg[CORDIC_STEPS])
            angle_next = DEG180_Q16 - ANG_W'(unsigned'(zc));
        else
            angle_next = ANG_W'(unsigned'(zc));
    end

    // valid and flag travel along the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg  <= '0;
            p2_ctl_reg  <= '0;
            dn_ctl_reg  <= '0;
            cc_ctl_reg  <= '0;
            cs_ctl_reg  <= '0;
            out_ctl_reg <= '0;
            for (int i = 0; i <= SQRT_STEPS; i++)
            begin
                sq_ctl_reg[i] <= '0;
                ps_ctl_reg[i] <= '0;
            end
            for (int i = 0; i <= DIV_STEPS; i++)
                dv_ctl_reg[i] <= '0;
            for (int i = 0; i <= CORDIC_STEPS; i++)
                co_ctl_reg[i] <= '0;
        end
        else
        begin
            p1_ctl_reg    <= ctl_in;
            p2_ctl_reg    <= p1_ctl_reg;
            sq_ctl_reg[0] <= p2_ctl_reg;
            for (int i = 0; i < SQRT_STEPS; i++)
                sq_ctl_reg[i+1] <= sq_ctl_reg[i];
            dn_ctl_reg    <= sq_ctl_reg[SQRT_STEPS];
            dv_ctl_reg[0] <= dn_ctl_reg;
            for (int i = 0; i < DIV_STEPS; i++)
                dv_ctl_reg[i+1] <= dv_ctl_reg[i];
            cc_ctl_reg    <= dv_ctl_reg[DIV_STEPS];
            cs_ctl_reg    <= cc_ctl_reg;
            ps_ctl_reg[0] <= cs_ctl_reg;
            for (int i = 0; i < SQRT_STEPS; i++)
                ps_ctl_reg[i+1] <= ps_ctl_reg[i];
            co_ctl_reg[0] <= ps_ctl_reg[SQRT_STEPS];
            for (int i = 0; i < CORDIC_STEPS; i++)
                co_ctl_reg[i+1] <= co_ctl_reg[i];
            out_ctl_reg   <= co_ctl_reg[CORDIC_STEPS];
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        // products
        prod_uv_reg[0] <= ux * vx;
        prod_uv_reg[1] <= uy * vy;
        prod_uv_reg[2] <= uz * vz;
        prod_uu_reg[0] <= ux * ux;
        prod_uu_reg[1] <= uy * uy;
        prod_uu_reg[2] <= uz * uz;
        prod_vv_reg[0] <= vx * vx;
        prod_vv_reg[1] <= vy * vy;
        prod_vv_reg[2] <= vz * vz;

        // sums
        dot_reg <= SUM_W'(prod_uv_reg[0]) + SUM_W'(prod_uv_reg[1]) + SUM_W'(prod_uv_reg[2]);
        su_reg  <= SUM_W'(unsigned'(prod_uu_reg[0])) + SUM_W'(unsigned'(prod_uu_reg[1]))
                 + SUM_W'(unsigned'(prod_uu_reg[2]));
        sv_reg  <= SUM_W'(unsigned'(prod_vv_reg[0])) + SUM_W'(unsigned'(prod_vv_reg[1]))
                 + SUM_W'(unsigned'(prod_vv_reg[2]));

        // magnitude roots, dot sign and size ride along
        sqa_reg[0].n  <= WIDE_W'(su_reg) << SQ_PRE;
        sqa_reg[0].r  <= '0;
        sqb_reg[0].n  <= WIDE_W'(sv_reg) << SQ_PRE;
        sqb_reg[0].r  <= '0;
        sq_neg_reg[0] <= dot_reg[SUM_W-1];
        sq_mag_reg[0] <= dot_reg[SUM_W-1] ? MAG_W'(-dot_reg) : MAG_W'(dot_reg);
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            sqa_reg[i+1]    <= sqrt_step(sqa_reg[i], WIDE_W'(1) << (WIDE_W - 2 - 2 * i));
            sqb_reg[i+1]    <= sqrt_step(sqb_reg[i], WIDE_W'(1) << (WIDE_W - 2 - 2 * i));
            sq_neg_reg[i+1] <= sq_neg_reg[i];
            sq_mag_reg[i+1] <= sq_mag_reg[i];
        end

        // denominator and numerator of the cosine
        den_reg    <= mu_w * mv_w;
        num_reg    <= WIDE_W'(sq_mag_reg[SQRT_STEPS]) << SQ_PRE;
        dn_neg_reg <= sq_neg_reg[SQRT_STEPS];

        // quotient one bit a stage
        dv_reg[0].rem  <= num_reg;
        dv_reg[0].q    <= '0;
        dv_den_reg[0]  <= den_reg;
        dv_sat_reg[0]  <= (num_reg >= den_reg);
        dv_neg_reg[0]  <= dn_neg_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            dv_reg[i+1]     <= div_step(dv_reg[i], dv_den_reg[i]);
            dv_den_reg[i+1] <= dv_den_reg[i];
            dv_sat_reg[i+1] <= dv_sat_reg[i];
            dv_neg_reg[i+1] <= dv_neg_reg[i];
        end

        // saturate cosine at one
        cc_c_reg   <= dv_sat_reg[DIV_STEPS] ? ROOT_W'(WIDE_W'(1) << CQ)
                                             : dv_reg[DIV_STEPS].q;
        cc_neg_reg <= dv_neg_reg[DIV_STEPS];

        // cosine squared
        csq_reg    <= c_w * c_w;
        cs_c_reg   <= cc_c_reg;
        cs_neg_reg <= cc_neg_reg;

        // sine root
        ps_reg[0].n   <= (WIDE_W'(1) << (2 * CQ)) - csq_reg;
        ps_reg[0].r   <= '0;
        ps_c_reg[0]   <= cs_c_reg;
        ps_neg_reg[0] <= cs_neg_reg;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            ps_reg[i+1]     <= sqrt_step(ps_reg[i], WIDE_W'(1) << (WIDE_W - 2 - 2 * i));
            ps_c_reg[i+1]   <= ps_c_reg[i];
            ps_neg_reg[i+1] <= ps_neg_reg[i];
        end

        // cordic vectoring toward the x axis
        co_x_reg[0]   <= signed'(XY_W'(ps_c_reg[SQRT_STEPS]));
        co_y_reg[0]   <= signed'(XY_W'(ps_reg[SQRT_STEPS].r[ROOT_W-1:0]));
        co_z_reg[0]   <= '0;
        co_neg_reg[0] <= ps_neg_reg[SQRT_STEPS];
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (co_y_reg[i] > 0)
            begin
                co_x_reg[i+1] <= co_x_reg[i] + (co_y_reg[i] >>> i);
                co_y_reg[i+1] <= co_y_reg[i] - (co_x_reg[i] >>> i);
                co_z_reg[i+1] <= co_z_reg[i] + signed'(ATAN_DEG_Q16[i]);
            end
            else
            begin
                co_x_reg[i+1] <= co_x_reg[i] - (co_y_reg[i] >>> i);
                co_y_reg[i+1] <= co_y_reg[i] + (co_x_reg[i] >>> i);
                co_z_reg[i+1] <= co_z_reg[i] - signed'(ATAN_DEG_Q16[i]);
            end
            co_neg_reg[i+1] <= co_neg_reg[i];
        end

        // final angle
        angle_reg <= angle_next;
    end

    assign ctl_out = out_ctl_reg;
    assign angle   = angle_reg;

endmodule

// File: design/triangle_min_angle.sv
// top level: smallest interior angle of a 3d triangle
//
// usage
//   one triangle is taken per transfer: start high with busy low at a rising
//   edge captures the nine vertex coordinates (signed, 12 fraction bits).
//   busy never rises, so a new triangle can be sent in every cycle.
//   each triangle yields exactly one result: done is high for one cycle with
//   min_angle (degrees, unsigned q8.8) and degenerate alongside it.
//   degenerate is set when any edge has zero length; min_angle is then 0.
// timing
//   throughput is one triangle per cycle. the pipeline depth comes from the
//   per-bit square root, divider and cordic stages in each angle unit.
// reset
//   rst_n clears all valid bits; nothing is in flight afterwards and no done
//   pulse appears until a triangle has gone through.
// receiver
//   results cannot be held off: each is presented for exactly one cycle.
module triangle_min_angle (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [tma_pkg::COORD_WIDTH-1:0] ax,
    input  logic signed [tma_pkg::COORD_WIDTH-1:0] ay,
    input  logic signed [tma_pkg::COORD_WIDTH-1:0] az,
    input  logic signed [tma_pkg::COORD_WIDTH-1:0] bx,
    input  logic signed [tma_pkg::COORD_WIDTH-1:0] by_coord,
    input  logic signed [tma_pkg::COORD_WIDTH-1:0] bz,
    input  logic signed [tma_pkg::COORD_WIDTH-1:0] cx,
    input  logic signed [tma_pkg::COORD_WIDTH-1:0] cy,
    input  logic signed [tma_pkg::COORD_WIDTH-1:0] cz,
    output logic                                   done,
    output logic [tma_pkg::OUT_W-1:0]              min_angle,
    output logic                                   degenerate
);
    import tma_pkg::*;

    ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg, mn_ctl_reg;
    ctl_t va_ctl [3];
    ctl_t s4_ctl_next;

    logic signed [COORD_WIDTH-1:0] vtx_reg [3][3];
    logic signed [DIFF_W-1:0]      diff_reg [3][3];
    logic signed [DIFF_W-1:0]      d3_reg [3][3];
    logic [DIFF_W-1:0]             mask_reg [3];
    logic [DIFF_W-1:0]             mask_next [3];
    logic signed [DIFF_W-1:0]      d4_reg [3][3];
    logic [SHIFT_W-1:0]            lsh_reg [3];
    logic [SHIFT_W-1:0]            rsh_reg [3];
    logic [SHIFT_W-1:0]            lsh_next [3];
    logic [SHIFT_W-1:0]            rsh_next [3];
    logic [POS_W-1:0]              pos [3];
    logic signed [NORM_W-1:0]      norm_reg [3][3];
    logic signed [NORM_W-1:0]      norm_next [3][3];
    logic signed [WIDE_W-1:0]      wide [3][3];
    logic [ANG_W-1:0]              ang [3];
    logic [ANG_W-1:0]              mn_next;
    logic [ANG_W-1:0]              a2;
    logic [ANG_W-1:0]              mn_reg;
    logic [ANG_W:0]                rounded;

    logic                          done_reg;
    logic [OUT_W-1:0]              min_angle_reg;
    logic                          degenerate_reg;

    // every triangle is taken as it arrives
    assign busy = 1'b0;

    // magnitude mask: the top set bit of the or of magnitudes is that of the max
    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            mask_next[v] = '0;
            for (int k = 0; k < 3; k++)
                mask_next[v] = mask_next[v]
                             | (diff_reg[v][k][DIFF_W-1] ? DIFF_W'(-diff_reg[v][k])
                                                         : DIFF_W'(diff_reg[v][k]));
        end
    end

    // leading one and normalizing shift amounts
    always_comb
    begin
        s4_ctl_next = s3_ctl_reg;
        for (int v = 0; v < 3; v++)
        begin
            pos[v] = '0;
            for (int b = 0; b < DIFF_W; b++)
                if (mask_reg[v][b])
                    pos[v] = POS_W'(b);
            if (int'(pos[v]) < NORM_MSB)
            begin
                lsh_next[v] = SHIFT_W'(NORM_MSB - int'(pos[v]));
                rsh_next[v] = '0;
            end
            else
            begin
                lsh_next[v] = '0;
                rsh_next[v] = SHIFT_W'(int'(pos[v]) - NORM_MSB);
            end
            if (mask_reg[v] == '0)
                s4_ctl_next.degen = 1'b1;
        end
    end

    // apply the shift, floor on the right
    always_comb
    begin
        for (int v = 0; v < 3; v++)
            for (int k = 0; k < 3; k++)
            begin
                wide[v][k]      = (WIDE_W'(d4_reg[v][k]) <<< lsh_reg[v]) >>> rsh_reg[v];
                norm_next[v][k] = wide[v][k][NORM_W-1:0];
            end
    end

    // smallest of the three angles, angle at b taken from its supplement
    always_comb
    begin
        a2      = DEG180_Q16 - ang[1];
        mn_next = ang[0];
        if (a2 < mn_next)
            mn_next = a2;
        if (ang[2] < mn_next)
            mn_next = ang[2];
    end

    assign rounded = (ANG_W'(mn_reg) + ROUND_INC) >> RND_SH;

    // control stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            mn_ctl_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_ctl_reg <= '{valid: start && !busy, degen: 1'b0};
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s4_ctl_next;
            s5_ctl_reg <= s4_ctl_reg;
            mn_ctl_reg <= va_ctl[0];
            done_reg   <= mn_ctl_reg.valid;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        vtx_reg[0][0] <= ax;
        vtx_reg[0][1] <= ay;
        vtx_reg[0][2] <= az;
        vtx_reg[1][0] <= bx;
        vtx_reg[1][1] <= by_coord;
        vtx_reg[1][2] <= bz;
        vtx_reg[2][0] <= cx;
        vtx_reg[2][1] <= cy;
        vtx_reg[2][2] <= cz;
        // edges ab, ac, bc
        for (int k = 0; k < 3; k++)
        begin
            diff_reg[0][k] <= DIFF_W'(vtx_reg[0][k]) - DIFF_W'(vtx_reg[1][k]);
            diff_reg[1][k] <= DIFF_W'(vtx_reg[0][k]) - DIFF_W'(vtx_reg[2][k]);
            diff_reg[2][k] <= DIFF_W'(vtx_reg[1][k]) - DIFF_W'(vtx_reg[2][k]);
        end
        d3_reg   <= diff_reg;
        mask_reg <= mask_next;
        d4_reg   <= d3_reg;
        lsh_reg  <= lsh_next;
        rsh_reg  <= rsh_next;
        norm_reg <= norm_next;
        mn_reg   <= mn_next;
        min_angle_reg  <= mn_ctl_reg.degen ? '0 : rounded[OUT_W-1:0];
        degenerate_reg <= mn_ctl_reg.degen;
    end

    // angle at a: ab against ac
    tma_vec_angle u_ang_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (s5_ctl_reg),
        .ux      (norm_reg[0][0]),
        .uy      (norm_reg[0][1]),
        .uz      (norm_reg[0][2]),
        .vx      (norm_reg[1][0]),
        .vy      (norm_reg[1][1]),
        .vz      (norm_reg[1][2]),
        .ctl_out (va_ctl[0]),
        .angle   (ang[0])
    );

    // outside angle at b: ab against bc
    tma_vec_angle u_ang_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (s5_ctl_reg),
        .ux      (norm_reg[0][0]),
        .uy      (norm_reg[0][1]),
        .uz      (norm_reg[0][2]),
        .vx      (norm_reg[2][0]),
        .vy      (norm_reg[2][1]),
        .vz      (norm_reg[2][2]),
        .ctl_out (va_ctl[1]),
        .angle   (ang[1])
    );

    // angle at c: bc against ac
    tma_vec_angle u_ang_c (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (s5_ctl_reg),
        .ux      (norm_reg[2][0]),
        .uy      (norm_reg[2][1]),
        .uz      (norm_reg[2][2]),
        .vx      (norm_reg[1][0]),
        .vy      (norm_reg[1][1]),
        .vz      (norm_reg[1][2]),
        .ctl_out (va_ctl[2]),
        .angle   (ang[2])
    );

    assign done       = done_reg;
    assign min_angle  = min_angle_reg;
    assign degenerate = degenerate_reg;

endmodule

// File: design/tma_checker.sv
// port-level checks for the triangle minimum angle block, bound to the top
module tma_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [tma_pkg::OUT_W-1:0] min_angle,
    input logic                      degenerate
);
    import tma_pkg::*;

    // the block never refuses a transfer
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("busy while start asserted");

    // a degenerate triangle reports a zero angle
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (min_angle == '0))
        else $error("degenerate result with nonzero angle");

    // the smallest interior angle cannot exceed a straight angle
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (min_angle <= MAX_ANGLE))
        else $error("angle out of range");

    // no result right after reset is released
    a_no_early_done: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result appeared out of reset");

endmodule

bind triangle_min_angle tma_checker u_tma_checker (.*);

// File: tb/tb_top.sv
// self-checking testbench for the triangle minimum angle block
module tb_top;
    import tma_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int LATENCY      = 131;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 1850;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct {
        logic [OUT_W-1:0] angle;
        logic             degen;
    } angle_res_t;

    typedef struct {
        coord_t           v [9];
        bit               typed;
        logic [OUT_W-1:0] angle;
        logic             degen;
    } tri_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    coord_t ax, ay, az, bx, by_coord, bz, cx, cy, cz;
    logic done;
    logic [OUT_W-1:0] min_angle;
    logic degenerate;

    angle_res_t angle_q [$];
    tri_row_t   tri_table [$];
    int         n_errors;
    int         n_sent;
    int         n_checked;
    int         n_degen;
    int         idle_cycles;

    triangle_min_angle DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by_coord(by_coord), .bz(bz),
        .cx(cx), .cy(cy), .cz(cz),
        .done(done), .min_angle(min_angle), .degenerate(degenerate)
    );

    // clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // floor square root of a 64-bit value
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        begin
            res  = 64'd0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    // scale an edge so its largest component magnitude is in [2^23, 2^24)
    function automatic bit scale_edge(inout longint e [3]);
        longint m;
        int     k;
        int     r;
        begin
            m = 0;
            k = 0;
            r = 0;
            for (int i = 0; i < 3; i++)
                if ((e[i] < 0 ? -e[i] : e[i]) > m)
                    m = (e[i] < 0 ? -e[i] : e[i]);
            if (m == 0)
                return 1'b0;
            while (m < (64'sd1 << 23))
            begin
                k++;
                m = m << 1;
            end
            while (m >= (64'sd1 << 24))
            begin
                r++;
                m = m >> 1;
            end
            for (int i = 0; i < 3; i++)
                e[i] = (k > 0) ? (e[i] <<< k) : (e[i] >>> r);
            return 1'b1;
        end
    endfunction

    // angle between two scaled edges, degrees with 16 fraction bits
    function automatic longint edge_angle(input longint u [3], input longint v [3]);
        longint      dot;
        longint      x, y, z, xs, ys;
        logic [63:0] su, sv, mu, mv, den, num, cq, rem, s;
        begin
            dot = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
            su  = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
            sv  = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
            mu  = isqrt64(su << 12);
            mv  = isqrt64(sv << 12);
            den = mu * mv;
            num = (dot < 0 ? -dot : dot);
            num = num << 12;
            // q30 cosine magnitude by restoring division
            if (num >= den)
                cq = 64'd1 << 30;
            else
            begin
                cq  = 0;
                rem = num;
                for (int i = 0; i < 30; i++)
                begin
                    rem = rem << 1;
                    cq  = cq << 1;
                    if (rem >= den)
                    begin
                        rem = rem - den;
                        cq  = cq | 64'd1;
                    end
                end
            end
            s = isqrt64((64'd1 << 60) - cq * cq);
            // cordic vectoring toward the x axis
            x = cq;
            y = s;
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_DEG_Q16[i]);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_DEG_Q16[i]);
                end
            end
            if (z < 0)
                z = 0;
            if (z > (longint'(90) << 16))
                z = longint'(90) << 16;
            return (dot >= 0) ? z : (longint'(180) << 16) - z;
        end
    endfunction

    // expected result for one triangle
    function automatic angle_res_t predict_min_angle(input coord_t p [9]);
        longint     ab [3], ac [3], bc [3];
        longint     a1, a2, a3, mn;
        bit         ok;
        angle_res_t r;
        begin
            for (int i = 0; i < 3; i++)
            begin
                ab[i] = longint'(p[i]) - longint'(p[3+i]);
                ac[i] = longint'(p[i]) - longint'(p[6+i]);
                bc[i] = longint'(p[3+i]) - longint'(p[6+i]);
            end
            ok = scale_edge(ab);
            ok = scale_edge(ac) && ok;
            ok = scale_edge(bc) && ok;
            if (!ok)
            begin
                r.angle = '0;
                r.degen = 1'b1;
                return r;
            end
            a1 = edge_angle(ab, ac);
            a2 = (longint'(180) << 16) - edge_angle(ab, bc);
            a3 = edge_angle(bc, ac);
            mn = a1;
            if (a2 < mn)
                mn = a2;
            if (a3 < mn)
                mn = a3;
            if (mn < 0)
                mn = 0;
            r.angle = OUT_W'((mn + (longint'(1) << (RND_SH - 1))) >> RND_SH);
            r.degen = 1'b0;
            return r;
        end
    endfunction

    task automatic add_row(input int a0, a1, a2, b0, b1, b2, c0, c1, c2,
                           input bit typed, input int ang, input bit dg);
        tri_row_t row;
        begin
            row.v = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0),
                      coord_t'(b1), coord_t'(b2), coord_t'(c0), coord_t'(c1),
                      coord_t'(c2)};
            row.typed = typed;
            row.angle = OUT_W'(ang);
            row.degen = dg;
            tri_table = {tri_table, row};
        end
    endtask

    // one transfer: hold the triangle until accepted, then log its expectation
    task automatic send_triangle(input coord_t p [9], input bit typed,
                                 input angle_res_t typed_res);
        angle_res_t exp_r;
        begin
            ax <= p[0]; ay <= p[1]; az <= p[2];
            bx <= p[3]; by_coord <= p[4]; bz <= p[5];
            cx <= p[6]; cy <= p[7]; cz <= p[8];
            start <= 1'b1;
            do
                @(posedge clk);
            while (busy);
            exp_r   = typed ? typed_res : predict_min_angle(p);
            angle_q = {angle_q, exp_r};
            n_sent++;
        end
    endtask

    // random triangle of a random kind
    task automatic make_triangle(output coord_t p [9]);
        int kind;
        int sc;
        int src;
        int dst;
        coord_t ext [5];
        begin
            ext  = '{coord_t'(-8388608), coord_t'(8388607), coord_t'(0),
                     coord_t'(-1), coord_t'(1)};
            kind = $urandom_range(0, 9);
            sc   = $urandom_range(0, 20);
            for (int i = 0; i < 9; i++)
                p[i] = coord_t'($urandom);
            case (kind)
                5, 6:
                    // small triangle around a random point
                    for (int i = 3; i < 9; i++)
                        p[i] = p[i%3] + coord_t'($signed($urandom_range(0, 2 << sc))
                                                  - (1 << sc));
                7:
                    // two vertices coincide
                    begin
                        src = $urandom_range(0, 2);
                        dst = (src + $urandom_range(1, 2)) % 3;
                        for (int i = 0; i < 3; i++)
                            p[3*dst + i] = p[3*src + i];
                    end
                8:
                    // collinear vertices; a zero offset makes them coincide
                    for (int i = 0; i < 3; i++)
                    begin
                        p[i]   = p[i] >>> 3;
                        p[3+i] = p[i] + (coord_t'($signed($urandom_range(0, 2 << sc))
                                                  - (1 << sc)) >>> 2);
                        p[6+i] = p[3+i] + 2 * (p[3+i] - p[i]);
                    end
                9:
                    for (int i = 0; i < 9; i++)
                        if ($urandom_range(0, 1))
                            p[i] = ext[$urandom_range(0, 4)];
                default: ;
            endcase
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        angle_res_t exp_r;
        if (rst_n && done)
        begin
            if (angle_q.size() == 0)
            begin
                $display("%0t: result with none expected: min_angle %0d degenerate %0b",
                         $time, min_angle, degenerate);
                n_errors++;
            end
            else
            begin
                exp_r = angle_q.pop_front();
                n_checked++;
                if (exp_r.degen)
                    n_degen++;
                if (min_angle !== exp_r.angle)
                begin
                    $display("%0t: min_angle expected %0d actual %0d",
                             $time, exp_r.angle, min_angle);
                    n_errors++;
                end
                if (degenerate !== exp_r.degen)
                begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, exp_r.degen, degenerate);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        coord_t     p [9];
        angle_res_t typed_res;
        int         burst_left;
        int         wait_cycles;
        start = 1'b0;
        ax = '0; ay = '0; az = '0; bx = '0; by_coord = '0; bz = '0;
        cx = '0; cy = '0; cz = '0;
        rst_n = 1'b0;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_degen = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed triangles: degenerate edges, extremes, right and collinear
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1);
        add_row(5, 6, 7, 5, 6, 7, 100, 0, 0, 1, 0, 1);
        add_row(5, 6, 7, 1, 2, 3, 1, 2, 3, 1, 0, 1);
        add_row(-8388608, 8388607, 0, 3, 3, 3, -8388608, 8388607, 0, 1, 0, 1);
        add_row(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0, 0);
        add_row(0, 0, 0, 4096, 0, 0, 2048, 3547, 0, 0, 0, 0);
        add_row(0, 0, 0, 1, 0, 0, 2, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 2, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 1000, 1, 0, 2000, 0, 0, 0, 0, 0);
        add_row(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                8388607, -8388608, 0, 0, 0, 0);
        add_row(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                -8388608, 8388607, -8388608, 0, 0, 0);
        add_row(-1, -1, -1, 0, 0, 0, 1, -1, 1, 0, 0, 0);
        add_row(8388607, 0, 0, -8388608, 0, 0, 0, 8388607, 0, 0, 0, 0);
        add_row(0, 0, 8388607, 0, 1, -8388608, 1, 0, 0, 0, 0, 0);
        add_row(-5592405, 5592405, -5592406, 5592405, -5592406, 5592405,
                1, 2, 3, 0, 0, 0);
        add_row(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0);
        add_row(0, 0, 0, 8388607, 8388607, 0, 8388607, 8388606, 0, 0, 0, 0);
        foreach (tri_table[i])
        begin
            typed_res.angle = tri_table[i].angle;
            typed_res.degen = tri_table[i].degen;
            send_triangle(tri_table[i].v, tri_table[i].typed, typed_res);
            if ($urandom_range(0, 2) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end

        // random triangles in bursts
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                // drain the pipeline once before going on
                start <= 1'b0;
                while (angle_q.size() != 0)
                    @(posedge clk);
            end
            if (burst_left == 0)
            begin
                burst_left  = $urandom_range(1, 40);
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (wait_cycles != 0)
                begin
                    start <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            burst_left--;
            make_triangle(p);
            send_triangle(p, 1'b0, typed_res);
        end
        start <= 1'b0;

        // drain
        while (angle_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d triangles, checked %0d results (%0d degenerate),",
                 n_sent, n_checked, n_degen);
        $display("in bursts with random gaps and one full drain midway.");
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
